/* rtl/nbc_pkg.sv */
// Shared constants, types and codes of the two-feature naive Bayes classifier.
`default_nettype none
package nbc_pkg;

	localparam int NUM_CLASSES    = 16;
	localparam int FEATURE_VALUES = 256;
	localparam int COUNT_WIDTH    = 16;

	localparam int CLASS_W = $clog2(NUM_CLASSES);
	localparam int FEAT_W  = $clog2(FEATURE_VALUES);
	localparam int ADDR_W  = CLASS_W + FEAT_W;
	localparam int DEPTH   = NUM_CLASSES * FEATURE_VALUES;
	localparam int SEEN_W  = $clog2(NUM_CLASSES + 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CLASS_W-1:0]     class_t;
	typedef logic [FEAT_W-1:0]      feat_t;
	typedef logic [SEEN_W-1:0]      seen_t;

	localparam logic OP_TRAIN    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRAIN_WR,
		ST_CL_RD,
		ST_CL_MUL,
		ST_CL_CROSS,
		ST_CL_CMP
	} state_t;

	typedef struct packed {
		logic   we;
		addr_t  waddr;
		count_t wdata;
	} ram_wr_t;

endpackage
`default_nettype wire

/* rtl/nbc_joint_ram.sv */
// Joint count memory: one write port and one read port with registered read data.
`default_nettype none
module nbc_joint_ram
	import nbc_pkg::*;
(
	input  wire logic    clk,
	input  wire ram_wr_t wr,
	input  wire addr_t   raddr,
	output logic         [COUNT_WIDTH-1:0] rdata
);

	count_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/naive_bayes_two_feature_classifier_top.sv */
// Top level of the two-feature categorical naive Bayes classifier.
//
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            opcode, feature_a, feature_b, class_label
// result    out        done (one-cycle strobe)   decided_class, no_data
//
// A train transaction does one joint memory read, then the write back.
// A classify transaction runs the read, multiply, cross-multiply and compare steps
// for each seen class; with no data, it ends with done and no_data set.
// After reset, a clearing pass zeroes both joint memories with busy high.
// The result strobe cannot be stalled; it rises in the cycle after the last step.
`default_nettype none
module naive_bayes_two_feature_classifier_top
	import nbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       opcode,
	input  wire logic [7:0] feature_a,
	input  wire logic [7:0] feature_b,
	input  wire logic [3:0] class_label,
	output logic            done,
	output logic      [3:0] decided_class,
	output logic            no_data
);

	typedef logic [2*COUNT_WIDTH-1:0] prod_t;
	typedef logic [3*COUNT_WIDTH-1:0] cross_t;

	function automatic count_t sat_inc(input count_t v);
		count_t r;
		r = (v == '1) ? v : count_t'(v + count_t'(1));
		return r;
	endfunction

	state_t  state_q, state_d;
	addr_t   clr_q;
	count_t  class_total_q [NUM_CLASSES];
	class_t  seen_q [NUM_CLASSES];
	seen_t   classes_seen_q;
	seen_t   k_q;
	feat_t   fa_q, fb_q;
	addr_t   tr_addr_a_q, tr_addr_b_q;
	prod_t   num_q, best_num_q;
	count_t  den_q, best_den_q;
	cross_t  lhs_q, rhs_q;
	class_t  best_cls_q;
	logic    done_q;
	class_t  decided_q;
	logic    no_data_q;

	ram_wr_t wr_a, wr_b;
	addr_t   raddr_a, raddr_b;
	count_t  rdata_a, rdata_b;
	class_t  cur_cls;
	logic    accept, last_k, win;
	class_t  best_cls_d;

	assign accept     = start && !busy;
	assign cur_cls    = seen_q[k_q[CLASS_W-1:0]];
	assign last_k     = (seen_t'(k_q + seen_t'(1)) == classes_seen_q);
	assign win        = (lhs_q > rhs_q);
	assign best_cls_d = win ? cur_cls : best_cls_q;

	nbc_joint_ram u_ram_a (
		.clk   (clk),
		.wr    (wr_a),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	nbc_joint_ram u_ram_b (
		.clk   (clk),
		.wr    (wr_b),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		wr_a    = '0;
		wr_b    = '0;
		raddr_a = {cur_cls, fa_q};
		raddr_b = {cur_cls, fb_q};
		unique case (state_q)
			ST_CLEAR: begin
				wr_a.we    = 1'b1;
				wr_a.waddr = clr_q;
				wr_b.we    = 1'b1;
				wr_b.waddr = clr_q;
				if (clr_q == addr_t'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy    = 1'b0;
				raddr_a = {class_t'(class_label), feat_t'(feature_a)};
				raddr_b = {class_t'(class_label), feat_t'(feature_b)};
				if (start) begin
					if (opcode == OP_TRAIN) begin
						state_d = ST_TRAIN_WR;
					end else if (classes_seen_q != '0) begin
						state_d = ST_CL_RD;
					end
				end
			end
			ST_TRAIN_WR: begin
				wr_a.we    = 1'b1;
				wr_a.waddr = tr_addr_a_q;
				wr_a.wdata = sat_inc(rdata_a);
				wr_b.we    = 1'b1;
				wr_b.waddr = tr_addr_b_q;
				wr_b.wdata = sat_inc(rdata_b);
				state_d    = ST_IDLE;
			end
			ST_CL_RD:    state_d = ST_CL_MUL;
			ST_CL_MUL:   state_d = ST_CL_CROSS;
			ST_CL_CROSS: state_d = ST_CL_CMP;
			ST_CL_CMP: begin
				state_d = last_k ? ST_IDLE : ST_CL_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			classes_seen_q <= '0;
			done_q         <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				class_total_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (state_q == ST_CLEAR) begin
				clr_q <= addr_t'(clr_q + addr_t'(1));
			end
			if (accept && opcode == OP_TRAIN) begin
				class_total_q[class_label] <= sat_inc(class_total_q[class_label]);
				if (class_total_q[class_label] == '0 &&
				    classes_seen_q < seen_t'(NUM_CLASSES)) begin
					classes_seen_q <= seen_t'(classes_seen_q + seen_t'(1));
				end
			end
			if (accept && opcode == OP_CLASSIFY && classes_seen_q == '0) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_CL_CMP && last_k) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_TRAIN && class_total_q[class_label] == '0 &&
		    classes_seen_q < seen_t'(NUM_CLASSES)) begin
			seen_q[classes_seen_q[CLASS_W-1:0]] <= class_t'(class_label);
		end
		if (accept) begin
			fa_q        <= feat_t'(feature_a);
			fb_q        <= feat_t'(feature_b);
			tr_addr_a_q <= {class_t'(class_label), feat_t'(feature_a)};
			tr_addr_b_q <= {class_t'(class_label), feat_t'(feature_b)};
			k_q         <= '0;
			best_num_q  <= '0;
			best_den_q  <= count_t'(1);
			best_cls_q  <= seen_q[0];
			decided_q   <= '0;
			no_data_q   <= 1'b1;
		end
		if (state_q == ST_CL_MUL) begin
			num_q <= prod_t'(rdata_a) * prod_t'(rdata_b);
			den_q <= class_total_q[cur_cls];
		end
		if (state_q == ST_CL_CROSS) begin
			lhs_q <= cross_t'(num_q) * cross_t'(best_den_q);
			rhs_q <= cross_t'(best_num_q) * cross_t'(den_q);
		end
		if (state_q == ST_CL_CMP) begin
			if (win) begin
				best_num_q <= num_q;
				best_den_q <= den_q;
				best_cls_q <= cur_cls;
			end
			k_q <= seen_t'(k_q + seen_t'(1));
			if (last_k) begin
				decided_q <= best_cls_d;
				no_data_q <= 1'b0;
			end
		end
	end

	assign done          = done_q;
	assign decided_class = 4'(decided_q);
	assign no_data       = no_data_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while a transaction is still in progress.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_CLASSIFY && classes_seen_q == '0) |=> (done && no_data))
		else $error("Classify with no training data did not flag an error.");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		classes_seen_q <= seen_t'(NUM_CLASSES))
		else $error("Seen class count exceeds the number of classes.");

	a_winner_trained: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !no_data) |-> (class_total_q[decided_q] != '0))
		else $error("Decided class has never been trained.");

	a_train_two: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_TRAIN) |=> (state_q == ST_TRAIN_WR && busy))
		else $error("Train transaction skipped its write back.");

endmodule
`default_nettype wire
